[rtl/core/mdbp_pkg.sv]
// ----------------------------------------------------------------------------
// mdbp_pkg
// Shared types and constants for the meter data block parser.
// ----------------------------------------------------------------------------
package mdbp_pkg;

  // field limits (characters beyond these are dropped)
  localparam int VALUE_CHARS  = 10;
  localparam int UNIT_CHARS   = 5;
  localparam int SERIAL_CHARS = 13;
  localparam int TYPE_CHARS   = 8;
  localparam int ID_CHARS     = 5;

  localparam int ID_LEN_W = 3;
  localparam int POS_W    = 4;
  localparam int SUM_W    = 7;

  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_ETX   = 8'h03;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_SLASH = 8'h2f;
  localparam logic [7:0] BYTE_LPAR  = 8'h28;
  localparam logic [7:0] BYTE_RPAR  = 8'h29;
  localparam logic [7:0] BYTE_STAR  = 8'h2a;
  localparam logic [7:0] BYTE_DOT   = 8'h2e;
  localparam logic [7:0] BYTE_0     = 8'h30;
  localparam logic [7:0] BYTE_1     = 8'h31;
  localparam logic [7:0] BYTE_2     = 8'h32;
  localparam logic [7:0] BYTE_3     = 8'h33;
  localparam logic [7:0] BYTE_6     = 8'h36;
  localparam logic [7:0] BYTE_8     = 8'h38;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_TYPE     = 3'd1,
    PH_WAIT_STX = 3'd2,
    PH_ID       = 3'd3,
    PH_VALUE    = 3'd4,
    PH_UNIT     = 3'd5,
    PH_REST     = 3'd6,
    PH_CHECK    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TYPE   = 3'd0,
    KIND_SERIAL = 3'd1,
    KIND_VALUE  = 3'd2,
    KIND_UNIT   = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_ENERGY = 2'd0,
    REG_VOLUME = 2'd1,
    REG_HOURS  = 2'd2,
    REG_NONE   = 2'd3
  } reg_sel_t;

  typedef struct packed {
    phase_t              phase;
    logic [SUM_W-1:0]    sum;
    logic [ID_LEN_W-1:0] id_len;
    logic [POS_W-1:0]    pos;
  } parse_state_t;

  typedef struct packed {
    kind_t            kind;
    logic [1:0]       reg_sel;
    logic [POS_W-1:0] index;
    logic [7:0]       value;
    logic [SUM_W-1:0] sum;
    logic             ok;
  } result_t;

endpackage

[rtl/core/mdbp_decode.sv]
// ----------------------------------------------------------------------------
// mdbp_decode
// Per-byte next-state and result logic of the frame parser.
// ----------------------------------------------------------------------------
module mdbp_decode import mdbp_pkg::*; #(
  parameter int IdChars = ID_CHARS
) (
  input  parse_state_t             cur,
  input  logic [IdChars-1:0][7:0]  id_cur,
  input  logic [7:0]               rx_byte,
  output parse_state_t             nxt,
  output logic [IdChars-1:0][7:0]  id_nxt,
  output result_t                  res,
  output logic                     res_hit
);

  localparam logic [ID_LEN_W-1:0] IdMax  = ID_LEN_W'(IdChars);
  localparam logic [ID_LEN_W-1:0] IdOver = ID_LEN_W'(IdChars + 1);

  logic [4:0][7:0]  id_pad;
  logic             len_ok;
  logic             is_serial;
  reg_sel_t         reg_sel;
  logic [POS_W-1:0] pos_inc;

  // id zero-padded to five characters, wider than any id compared
  always_comb begin
    id_pad = '0;
    for (int i = 0; i < IdChars; i++) begin
      id_pad[i] = id_cur[i];
    end
  end

  assign len_ok    = (cur.id_len <= IdMax);
  assign is_serial = len_ok && (cur.id_len != '0) && (id_pad[0] == BYTE_0);
  assign pos_inc   = (cur.pos == '1) ? cur.pos : cur.pos + POS_W'(1);

  always_comb begin
    reg_sel = REG_NONE;
    if (len_ok && cur.id_len == ID_LEN_W'(3) && id_pad[0] == BYTE_6 &&
        id_pad[1] == BYTE_DOT && id_pad[2] == BYTE_8) begin
      reg_sel = REG_ENERGY;
    end else if (len_ok && cur.id_len == ID_LEN_W'(4) && id_pad[0] == BYTE_6 &&
                 id_pad[1] == BYTE_DOT && id_pad[2] == BYTE_2 &&
                 id_pad[3] == BYTE_6) begin
      reg_sel = REG_VOLUME;
    end else if (len_ok && cur.id_len == ID_LEN_W'(4) && id_pad[0] == BYTE_6 &&
                 id_pad[1] == BYTE_DOT && id_pad[2] == BYTE_3 &&
                 id_pad[3] == BYTE_1) begin
      reg_sel = REG_HOURS;
    end
  end

  always_comb begin
    nxt     = cur;
    id_nxt  = id_cur;
    res     = '0;
    res_hit = 1'b0;
    res.value = rx_byte;
    res.index = cur.pos;

    case (cur.phase)
      PH_IDLE: begin
        if (rx_byte == BYTE_SLASH) begin
          nxt.pos   = '0;
          nxt.phase = PH_TYPE;
        end
      end
      PH_TYPE, PH_WAIT_STX: begin
        if (rx_byte == BYTE_STX) begin
          nxt.sum    = '0;
          id_nxt     = '0;
          nxt.id_len = '0;
          nxt.pos    = '0;
          nxt.phase  = PH_ID;
        end else if (cur.phase == PH_TYPE) begin
          if (rx_byte == BYTE_CR) begin
            nxt.phase = PH_WAIT_STX;
          end else begin
            res.kind = KIND_TYPE;
            res_hit  = (cur.pos < POS_W'(TYPE_CHARS));
            nxt.pos  = pos_inc;
          end
        end
      end
      PH_CHECK: begin
        res.kind  = KIND_END;
        res.index = '0;
        res.sum   = cur.sum;
        res.ok    = (rx_byte == {1'b0, cur.sum});
        res_hit   = 1'b1;
        nxt.phase = PH_IDLE;
      end
      default: begin
        if (rx_byte == BYTE_STX) begin
          nxt.sum    = '0;
          id_nxt     = '0;
          nxt.id_len = '0;
          nxt.pos    = '0;
          nxt.phase  = PH_ID;
        end else begin
          nxt.sum = cur.sum + rx_byte[SUM_W-1:0];
          if (rx_byte == BYTE_ETX) begin
            nxt.phase = PH_CHECK;
          end else if (rx_byte inside {BYTE_CR, BYTE_LF}) begin
            id_nxt     = '0;
            nxt.id_len = '0;
            nxt.pos    = '0;
            nxt.phase  = PH_ID;
          end else begin
            case (cur.phase)
              PH_ID: begin
                if (rx_byte == BYTE_LPAR) begin
                  nxt.pos   = '0;
                  nxt.phase = PH_VALUE;
                end else if (cur.id_len < IdMax) begin
                  for (int i = 0; i < IdChars; i++) begin
                    if (cur.id_len == ID_LEN_W'(i)) begin
                      id_nxt[i] = rx_byte;
                    end
                  end
                  nxt.id_len = cur.id_len + ID_LEN_W'(1);
                end else begin
                  // overlong id: mark it so it matches nothing
                  nxt.id_len = IdOver;
                end
              end
              PH_VALUE: begin
                if (rx_byte == BYTE_RPAR) begin
                  nxt.phase = PH_REST;
                end else if (is_serial) begin
                  res.kind = KIND_SERIAL;
                  res_hit  = (cur.pos < POS_W'(SERIAL_CHARS));
                  nxt.pos  = pos_inc;
                end else if (rx_byte == BYTE_STAR) begin
                  nxt.pos   = '0;
                  nxt.phase = PH_UNIT;
                end else begin
                  res.kind    = KIND_VALUE;
                  res.reg_sel = reg_sel;
                  res_hit     = (reg_sel != REG_NONE) &&
                                (cur.pos < POS_W'(VALUE_CHARS));
                  nxt.pos     = pos_inc;
                end
              end
              PH_UNIT: begin
                if (rx_byte == BYTE_RPAR) begin
                  nxt.phase = PH_REST;
                end else begin
                  res.kind    = KIND_UNIT;
                  res.reg_sel = reg_sel;
                  res_hit     = (reg_sel != REG_NONE) &&
                                (cur.pos < POS_W'(UNIT_CHARS));
                  nxt.pos     = pos_inc;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    endcase
  end

endmodule

[rtl/core/mdbp_out_reg.sv]
// ----------------------------------------------------------------------------
// mdbp_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module mdbp_out_reg import mdbp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  logic    load_hit,
  input  result_t load_res,
  output logic    busy,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // full and held by the consumer: no room for a new word
  assign busy = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = load_hit;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_hit) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[rtl/core/meter_data_block_parser.sv]
// ----------------------------------------------------------------------------
// meter_data_block_parser - readout frame byte parser
// Output: a result word is registered and valid in the cycle after its byte is taken.
// Throughput: one byte per cycle while no full output word is held by out_stall.
// Reset: synchronous, active low; parser idle waiting for '/', output empty.
// ----------------------------------------------------------------------------
module meter_data_block_parser import mdbp_pkg::*; #(
  parameter int IdChars = ID_CHARS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_item_kind,
  output logic [1:0]          out_register_select,
  output logic [POS_W-1:0]    out_char_index,
  output logic [7:0]          out_char_value,
  output logic [SUM_W-1:0]    out_check_sum,
  output logic                out_check_ok
);

  parse_state_t            state_r;
  parse_state_t            state_nxt;
  logic [IdChars-1:0][7:0] id_text_r;
  logic [IdChars-1:0][7:0] id_text_nxt;
  result_t                 res;
  logic                    res_hit;
  result_t                 out_res;
  logic                    busy;
  logic                    in_acc;

  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;

  mdbp_decode #(
    .IdChars (IdChars)
  ) u_decode (
    .cur     (state_r),
    .id_cur  (id_text_r),
    .rx_byte (in_rx_byte),
    .nxt     (state_nxt),
    .id_nxt  (id_text_nxt),
    .res     (res),
    .res_hit (res_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= '{phase: PH_IDLE, sum: '0, id_len: '0, pos: '0};
      id_text_r <= '0;
    end else if (in_acc) begin
      state_r   <= state_nxt;
      id_text_r <= id_text_nxt;
    end
  end

  mdbp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .load_hit  (res_hit),
    .load_res  (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_item_kind       = out_res.kind;
  assign out_register_select = out_res.reg_sel;
  assign out_char_index      = out_res.index;
  assign out_char_value      = out_res.value;
  assign out_check_sum       = out_res.sum;
  assign out_check_ok        = out_res.ok;

endmodule

[bench/meter_data_block_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_data_block_parser_tb - readout frame parser testbench
// Feeds directed and random readout frames, well formed and broken, byte by
// byte under random sender gaps and receiver stalls. A frame model predicts
// every extracted character and frame-end word; results are checked in order.
// ----------------------------------------------------------------------------
import mdbp_pkg::*;

class frame_scoreboard;
  phase_t           phase;
  logic [SUM_W-1:0] sum;
  logic [7:0]       id_text[ID_CHARS];
  int               id_len;
  logic [POS_W-1:0] pos;
  result_t          expected_q[$];
  int               errors;

  function new();
    phase  = PH_IDLE;
    sum    = '0;
    errors = 0;
    clear_line();
    phase  = PH_IDLE;
  endfunction

  function void clear_line();
    foreach (id_text[i]) id_text[i] = 8'h00;
    id_len = 0;
    pos    = '0;
    phase  = PH_ID;
  endfunction

  function void bump();
    if (pos != '1) pos = pos + 1'b1;
  endfunction

  // exact match only: an overlong id never matches
  function bit id_is(string s);
    if (id_len != s.len() || id_len > ID_CHARS) return 0;
    for (int i = 0; i < s.len(); i++)
      if (id_text[i] != s[i]) return 0;
    return 1;
  endfunction

  function reg_sel_t id_register();
    if (id_is("6.8"))  return REG_ENERGY;
    if (id_is("6.26")) return REG_VOLUME;
    if (id_is("6.31")) return REG_HOURS;
    return REG_NONE;
  endfunction

  function bit id_is_serial();
    return id_len >= 1 && id_len <= ID_CHARS && id_text[0] == BYTE_0;
  endfunction

  function void push_char(kind_t k, logic [1:0] r, logic [POS_W-1:0] idx, logic [7:0] c);
    result_t w;
    w.kind    = k;
    w.reg_sel = r;
    w.index   = idx;
    w.value   = c;
    w.sum     = '0;
    w.ok      = 1'b0;
    expected_q.push_back(w);
  endfunction

  function void note_byte(logic [7:0] b);
    logic [POS_W-1:0] p;
    reg_sel_t         r;
    result_t          w;
    p = pos;
    case (phase)
      PH_IDLE: begin
        if (b == BYTE_SLASH) begin
          pos   = '0;
          phase = PH_TYPE;
        end
      end
      PH_TYPE, PH_WAIT_STX: begin
        if (b == BYTE_STX) begin
          sum = '0;
          clear_line();
        end else if (phase == PH_TYPE) begin
          if (b == BYTE_CR) begin
            phase = PH_WAIT_STX;
          end else begin
            if (p < TYPE_CHARS) push_char(KIND_TYPE, 2'd0, p, b);
            bump();
          end
        end
      end
      PH_CHECK: begin
        w.kind    = KIND_END;
        w.reg_sel = 2'd0;
        w.index   = '0;
        w.value   = b;
        w.sum     = sum;
        w.ok      = (b == {1'b0, sum});
        expected_q.push_back(w);
        phase = PH_IDLE;
      end
      default: begin
        if (b == BYTE_STX) begin
          sum = '0;
          clear_line();
        end else begin
          sum = sum + b[SUM_W-1:0];
          if (b == BYTE_ETX) begin
            phase = PH_CHECK;
          end else if (b == BYTE_CR || b == BYTE_LF) begin
            clear_line();
          end else begin
            case (phase)
              PH_ID: begin
                if (b == BYTE_LPAR) begin
                  pos   = '0;
                  phase = PH_VALUE;
                end else if (id_len < ID_CHARS) begin
                  id_text[id_len] = b;
                  id_len++;
                end else begin
                  id_len = ID_CHARS + 1;
                end
              end
              PH_VALUE: begin
                if (id_is_serial()) begin
                  if (b == BYTE_RPAR) begin
                    phase = PH_REST;
                  end else begin
                    if (p < SERIAL_CHARS) push_char(KIND_SERIAL, 2'd0, p, b);
                    bump();
                  end
                end else if (b == BYTE_RPAR) begin
                  phase = PH_REST;
                end else if (b == BYTE_STAR) begin
                  pos   = '0;
                  phase = PH_UNIT;
                end else begin
                  r = id_register();
                  if (r != REG_NONE && p < VALUE_CHARS) push_char(KIND_VALUE, r, p, b);
                  bump();
                end
              end
              PH_UNIT: begin
                if (b == BYTE_RPAR) begin
                  phase = PH_REST;
                end else begin
                  r = id_register();
                  if (r != REG_NONE && p < UNIT_CHARS) push_char(KIND_UNIT, r, p, b);
                  bump();
                end
              end
              default: ;
            endcase
          end
        end
      end
    endcase
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_word(result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected word: item_kind %0d, char_value %0h", got.kind, got.value);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("item_kind", 8'(want.kind), 8'(got.kind));
    compare_field("register_select", 8'(want.reg_sel), 8'(got.reg_sel));
    compare_field("char_index", 8'(want.index), 8'(got.index));
    compare_field("char_value", want.value, got.value);
    compare_field("check_sum", 8'(want.sum), 8'(got.sum));
    compare_field("check_ok", 8'(want.ok), 8'(got.ok));
  endfunction
endclass

module meter_data_block_parser_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       out_item_kind;
  logic [1:0]       out_register_select;
  logic [POS_W-1:0] out_char_index;
  logic [7:0]       out_char_value;
  logic [SUM_W-1:0] out_check_sum;
  logic             out_check_ok;

  frame_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;

  logic [7:0]       frame_q[$];
  logic [SUM_W-1:0] frame_sum;
  string            near_ids[6] = '{"6.2", "6.260", "6.3", "6.81", "6.80", "6.311"};

  meter_data_block_parser u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_item_kind       (out_item_kind),
    .out_register_select (out_register_select),
    .out_char_index      (out_char_index),
    .out_char_value      (out_char_value),
    .out_check_sum       (out_check_sum),
    .out_check_ok        (out_check_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: check taken words, then pick next stall
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.kind    = kind_t'(out_item_kind);
      got.reg_sel = out_register_select;
      got.index   = out_char_index;
      got.value   = out_char_value;
      got.sum     = out_check_sum;
      got.ok      = out_check_ok;
      sb.check_word(got);
    end
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frame_q.delete();
  endtask

  // sum restarts at STX, as in the block
  function automatic void put(input logic [7:0] b);
    frame_q.push_back(b);
    if (b == BYTE_STX) frame_sum = '0;
    else frame_sum = frame_sum + b[SUM_W-1:0];
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] b;
    if ($urandom_range(9) == 0) return 8'($urandom_range(8'h80, 8'hff));
    do b = 8'($urandom_range(8'h21, 8'h7e));
    while (b == BYTE_LPAR || b == BYTE_RPAR || b == BYTE_STAR);
    return b;
  endfunction

  function automatic void put_line();
    case ($urandom_range(0, 8))
      0, 1: begin
        put(BYTE_0);
        repeat ($urandom_range(0, 4)) put(rand_text());
      end
      2: put_str("6.8");
      3: put_str("6.26");
      4: put_str("6.31");
      5: put_str(near_ids[$urandom_range(0, 5)]);
      6: begin
        put_str("6.26");
        repeat ($urandom_range(2, 4)) put(rand_text());
      end
      7: repeat ($urandom_range(1, 5)) put(rand_text());
      default: ;
    endcase
    put(BYTE_LPAR);
    repeat ($urandom_range(0, 16)) put(rand_text());
    if ($urandom_range(3) != 0) begin
      put(BYTE_STAR);
      repeat ($urandom_range(0, 7)) put(rand_text());
    end
    if ($urandom_range(9) != 0) put(BYTE_RPAR);
    if ($urandom_range(7) == 0) repeat ($urandom_range(1, 3)) put(rand_text());
  endfunction

  function automatic void build_good_frame();
    frame_sum = '0;
    put(BYTE_SLASH);
    repeat ($urandom_range(0, 12)) put(rand_text());
    put(BYTE_CR);
    put(BYTE_LF);
    if ($urandom_range(9) == 0) put(rand_text());
    put(BYTE_STX);
    repeat ($urandom_range(1, 5)) begin
      put_line();
      case ($urandom_range(0, 9))
        0: put(BYTE_CR);
        1: put(BYTE_LF);
        default: begin
          put(BYTE_CR);
          put(BYTE_LF);
        end
      endcase
    end
    put_str("!");
    put(BYTE_CR);
    put(BYTE_LF);
    put(BYTE_ETX);
    if ($urandom_range(3) != 0) frame_q.push_back({1'b0, frame_sum});
    else frame_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_random_frame();
    int n;
    case ($urandom_range(0, 9))
      0: begin
        if ($urandom_range(1)) put(BYTE_SLASH);
        repeat ($urandom_range(5, 30)) put(8'($urandom_range(0, 255)));
      end
      1: begin
        // cut short; the next frame has to recover
        build_good_frame();
        n = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > n) void'(frame_q.pop_back());
      end
      default: build_good_frame();
    endcase
    send_frame();
  endtask

  task automatic run_random(input int idle, input int stall, input int count);
    int start;
    send_idle_pct = idle;
    stall_pct     = stall;
    start         = bytes_sent;
    while (bytes_sent - start < count) send_random_frame();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle noise, overlong type text ended by STX, serial with star and
    // saturating position, text after ')', long values, restart by STX
    frame_sum = '0;
    put(8'h00);
    put(8'hff);
    put(BYTE_SLASH);
    put_str("ABCDEFGHIJKLMNOP");
    put(BYTE_STX);
    put_str("0(12*3456789ABCDEFGH)zz");
    put(BYTE_CR);
    put(BYTE_LF);
    put_str("6.8(0123456789AB*kWhxyz)");
    put(BYTE_CR);
    put(BYTE_LF);
    put_str("6.26(0");
    put(8'hff);
    put_str("*m3)");
    put(BYTE_STX);
    put_str("6.31(5");
    put(BYTE_CR);
    put_str("6.31(7*h)");
    put(BYTE_LF);
    put_str("6.26.1(9*x)");
    put(BYTE_CR);
    put(BYTE_LF);
    put_str("!");
    put(BYTE_CR);
    put(BYTE_LF);
    put(BYTE_ETX);
    frame_q.push_back({1'b1, frame_sum});
    send_frame();
    // type text ended by CR, junk before STX, matching check byte
    put(BYTE_SLASH);
    put_str("AB");
    put(BYTE_CR);
    put(BYTE_LF);
    put_str("q");
    put(BYTE_STX);
    put_str("6.8(1*k)");
    put(BYTE_ETX);
    frame_q.push_back({1'b0, frame_sum});
    send_frame();

    run_random(0, 0, 220);
    run_random(80, 0, 220);
    run_random(0, 80, 220);
    run_random(12, 12, 220);

    // long receiver hold while bytes keep coming
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests++;
    put(BYTE_SLASH);
    put_str("ABCDEFGH");
    put(BYTE_CR);
    put(BYTE_LF);
    put(BYTE_STX);
    put_str("6.8(1234567890*kWh)");
    put(BYTE_CR);
    put(BYTE_LF);
    put_str("6.26(1234567890*m3)");
    put(BYTE_CR);
    put(BYTE_LF);
    put_str("!");
    put(BYTE_CR);
    put(BYTE_LF);
    put(BYTE_ETX);
    frame_q.push_back({1'b0, frame_sum});
    send_frame();
    run_random(0, 0, 60);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected words never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
